/* rtl/plst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg: shared types and constants for the positional list store
// Request modes, result status codes, control state and cell command bundle.
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIND   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2
    } plst_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADPOS  = 2'd2,
        ST_MISSING = 2'd3
    } plst_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_FIND = 1'b1
    } plst_state_t;

    // command broadcast to every cell in the chain
    typedef struct packed {
        logic ins;
        logic del;
        logic fnd;
    } plst_cmd_t;

endpackage

/* rtl/plst_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_cell: one list slot
// Holds one entry; on insert takes its left neighbor or the new value, on
// delete takes its right neighbor, on find registers an equality match.
// ----------------------------------------------------------------------------
module plst_cell #(
    parameter int DEPTH       = plst_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = plst_pkg::VALUE_WIDTH_DEF,
    parameter int IDX         = 0
) (
    input  logic                          aclk,
    input  plst_pkg::plst_cmd_t           cmd,
    input  logic [$clog2(DEPTH)-1:0]      pos0,
    input  logic [VALUE_WIDTH-1:0]        value,
    input  logic [$clog2(DEPTH+1)-1:0]    count,
    input  logic [VALUE_WIDTH-1:0]        left_data,
    input  logic [VALUE_WIDTH-1:0]        right_data,
    output logic [VALUE_WIDTH-1:0]        data_out,
    output logic                          match_out
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] IDX_I = IW'(IDX);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   match_reg;
    logic                   match_next;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (IDX_I > pos0) begin
                entry_next = left_data;
            end else if (IDX_I == pos0) begin
                entry_next = value;
            end
        end else if (cmd.del) begin
            if (IDX_I >= pos0) begin
                entry_next = right_data;
            end
        end
    end

    // only slots inside the current length can match
    always_comb begin
        match_next = match_reg;
        if (cmd.fnd) begin
            match_next = (entry_reg == value) && (IDX_C < count);
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign data_out  = entry_reg;
    assign match_out = match_reg;

endmodule

/* rtl/plst_find.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_find: lowest-match encoder
// Isolates the lowest set bit of the match vector and encodes its index.
// ----------------------------------------------------------------------------
module plst_find #(
    parameter int DEPTH = plst_pkg::DEPTH_DEF
) (
    input  logic [DEPTH-1:0]         match,
    output logic                     hit,
    output logic [$clog2(DEPTH)-1:0] idx
);

    localparam int IW = $clog2(DEPTH);

    logic [DEPTH-1:0] lowest;

    assign lowest = match & (~match + DEPTH'(1));
    assign hit    = |match;

    // lowest is one-hot, so each index bit is an OR over its slots
    always_comb begin
        idx = '0;
        for (int b = 0; b < IW; b++) begin
            for (int k = 0; k < DEPTH; k++) begin
                if (((k >> b) & 1) == 1) begin
                    idx[b] = idx[b] | lowest[k];
                end
            end
        end
    end

endmodule

/* rtl/positional_list_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list with find, insert and delete
// Chain of slot cells with a shared command bus and a lowest-match encoder.
// ----------------------------------------------------------------------------
// Entries live in a row of DEPTH cells; insert and delete shift the cells one
// step toward or away from the requested 1-based position, and their result
// is registered at the same edge the request is taken. For a find, every
// cell compares its entry at the accept edge, then the lowest-match encoder
// fills the result register. A new request is taken while the control is
// idle and the result register is empty or being drained in that cycle. The
// list is empty after reset and needs no clearing pass. Length and found
// index are reported in their 6- and 5-bit fields.
// ----------------------------------------------------------------------------
module positional_list_store #(
    parameter int DEPTH       = plst_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = plst_pkg::VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_value,
    input  logic [5:0]  s_position,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_found_index,
    output logic [5:0]  m_length
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    plst_pkg::plst_state_t  state_reg;
    plst_pkg::plst_state_t  state_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    plst_pkg::plst_status_t m_status_reg;
    plst_pkg::plst_status_t m_status_next;
    logic [4:0]             m_index_reg;
    logic [4:0]             m_index_next;
    logic [5:0]             m_length_reg;
    logic [5:0]             m_length_next;

    logic                   acc;
    plst_pkg::plst_mode_t   mode_in;
    logic [VALUE_WIDTH-1:0] val_in;
    logic [PW-1:0]          pos_ext;
    logic [PW-1:0]          cnt_ext;
    logic                   ins_pos_ok;
    logic                   del_pos_ok;
    logic [IW-1:0]          pos0;
    plst_pkg::plst_cmd_t    dec_cmd;
    plst_pkg::plst_cmd_t    cell_cmd;
    plst_pkg::plst_status_t dec_status;

    logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]       match_vec;
    logic                   find_hit;
    logic [IW-1:0]          find_idx;

    assign acc     = s_valid && s_ready;
    assign mode_in = plst_pkg::plst_mode_t'(s_mode);
    assign val_in  = VALUE_WIDTH'(s_value);
    assign pos_ext = PW'(s_position);
    assign cnt_ext = PW'(count_reg);

    assign ins_pos_ok = (pos_ext != '0) && ((pos_ext - PW'(1)) <= cnt_ext);
    assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign pos0       = IW'(pos_ext - PW'(1));

    // request decode
    always_comb begin
        dec_cmd    = '0;
        dec_status = plst_pkg::ST_OK;
        unique case (mode_in)
            plst_pkg::MODE_FIND: begin
                dec_cmd.fnd = 1'b1;
            end
            plst_pkg::MODE_INSERT: begin
                if (count_reg >= FULL_C) begin
                    dec_status = plst_pkg::ST_FULL;
                end else if (ins_pos_ok) begin
                    dec_cmd.ins = 1'b1;
                end else begin
                    dec_status = plst_pkg::ST_BADPOS;
                end
            end
            plst_pkg::MODE_DELETE: begin
                if (del_pos_ok) begin
                    dec_cmd.del = 1'b1;
                end else begin
                    dec_status = plst_pkg::ST_BADPOS;
                end
            end
            default: begin
                dec_status = plst_pkg::ST_BADPOS;
            end
        endcase
    end

    assign cell_cmd = acc ? dec_cmd : '0;

    always_comb begin
        count_next = count_reg;
        if (cell_cmd.ins) begin
            count_next = count_reg + CW'(1);
        end else if (cell_cmd.del) begin
            count_next = count_reg - CW'(1);
        end
    end

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_w;
        logic [VALUE_WIDTH-1:0] right_w;

        if (g == 0) begin : g_first
            assign left_w = val_in;
        end else begin : g_mid_l
            assign left_w = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = cell_data[g];
        end else begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        plst_cell #(
            .DEPTH       (DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (g)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd),
            .pos0       (pos0),
            .value      (val_in),
            .count      (count_reg),
            .left_data  (left_w),
            .right_data (right_w),
            .data_out   (cell_data[g]),
            .match_out  (match_vec[g])
        );
    end

    plst_find #(
        .DEPTH (DEPTH)
    ) u_find (
        .match (match_vec),
        .hit   (find_hit),
        .idx   (find_idx)
    );

    // control: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            plst_pkg::S_IDLE: begin
                if (acc && dec_cmd.fnd) begin
                    state_next = plst_pkg::S_FIND;
                end
            end
            plst_pkg::S_FIND: begin
                state_next = plst_pkg::S_IDLE;
            end
            default: begin
                state_next = plst_pkg::S_IDLE;
            end
        endcase
    end

    // control: outputs
    always_comb begin
        s_ready = 1'b0;
        unique case (state_reg)
            plst_pkg::S_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
            end
            plst_pkg::S_FIND: begin
                s_ready = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // result register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_index_next  = m_index_reg;
        m_length_next = m_length_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == plst_pkg::S_FIND) begin
            m_valid_next  = 1'b1;
            m_status_next = find_hit ? plst_pkg::ST_OK : plst_pkg::ST_MISSING;
            m_index_next  = find_hit ? 5'(find_idx) : 5'd0;
            m_length_next = 6'(count_reg);
        end else if (acc && !dec_cmd.fnd) begin
            m_valid_next  = 1'b1;
            m_status_next = dec_status;
            m_index_next  = 5'd0;
            m_length_next = 6'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= plst_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_index_reg  <= m_index_next;
        m_length_reg <= m_length_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_index = m_index_reg;
    assign m_length      = m_length_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_C)
        else $error("list length above depth");

    a_find_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == plst_pkg::S_FIND |-> !m_valid_reg)
        else $error("find result has no free output slot");

    a_full_insert_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && mode_in == plst_pkg::MODE_INSERT && count_reg == FULL_C
        |=> $stable(count_reg))
        else $error("insert into full list changed length");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == plst_pkg::S_FIND && find_hit |-> CW'(find_idx) < count_reg)
        else $error("find matched outside the list");

endmodule
